@@ rtl/iis_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iis_pkg
// Shared widths, pipeline records and sequencer states for the IMU increment
// splitter.
// ----------------------------------------------------------------------------
package iis_pkg;

  localparam int TIME_BITS     = 48;
  localparam int INC_BITS      = 32;
  localparam int FRAC_BITS     = 32;
  localparam int SDT_BITS      = 32;
  localparam int DT_BITS       = 33;
  localparam int INC_OUT_BITS  = INC_BITS + 1;
  localparam int NUM_LANES     = 6;
  localparam int MIN_BITS      = 10;
  localparam int IN_DATA_BITS  = 3 * TIME_BITS + SDT_BITS + NUM_LANES * INC_BITS;
  localparam int OUT_FIELD_BITS = TIME_BITS + DT_BITS + NUM_LANES * INC_OUT_BITS;
  localparam int OUT_DATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
  localparam int NUM_STAGES    = FRAC_BITS + 2;

  // Item as it travels down the divider
  typedef struct packed {
    logic                               flag;
    logic [TIME_BITS-1:0]               tc;
    logic [TIME_BITS-1:0]               ts;
    logic [TIME_BITS-1:0]               hd;
    logic [TIME_BITS-1:0]               iv;
    logic [TIME_BITS-1:0]               rem;
    logic [FRAC_BITS-1:0]               q;
    logic [SDT_BITS-1:0]                sdt;
    logic [NUM_LANES-1:0][INC_BITS-1:0] inc;
  } iis_pipe_t;

  // Per-item segment summary handed to the output sequencer
  typedef struct packed {
    logic                 rej;
    logic                 ok;
    logic [TIME_BITS-1:0] ts;
    logic [TIME_BITS-1:0] tc;
    logic [DT_BITS-1:0]   hdt;
    logic [DT_BITS-1:0]   tdt;
  } iis_seg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HEAD,
    ST_TAIL
  } iis_state_t;

endpackage

@@ rtl/iis_div_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iis_div_stage
// One restoring-division step: produces one quotient bit of the split
// fraction and carries the rest of the item along.
// ----------------------------------------------------------------------------
module iis_div_stage import iis_pkg::*; (
  input  logic      clk,
  input  logic      en,
  input  iis_pipe_t d_in,
  output iis_pipe_t d_out
);

  logic [TIME_BITS:0] shifted;
  logic [TIME_BITS:0] diff;
  logic               ge;
  iis_pipe_t          pipe_r;
  iis_pipe_t          pipe_nxt;

  // Shift, compare, conditionally subtract
  always_comb begin
    shifted  = {d_in.rem, 1'b0};
    diff     = shifted - {1'b0, d_in.iv};
    ge       = (shifted >= {1'b0, d_in.iv});
    pipe_nxt = d_in;
    pipe_nxt.rem = ge ? diff[TIME_BITS-1:0] : shifted[TIME_BITS-1:0];
    pipe_nxt.q   = {d_in.q[FRAC_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe_r <= pipe_nxt;
    end
  end

  assign d_out = pipe_r;

endmodule

@@ rtl/iis_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iis_lane
// Scales one increment by the split fraction: registered magnitude product,
// then head and remainder with the sign of the increment restored.
// ----------------------------------------------------------------------------
module iis_lane import iis_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic [INC_BITS-1:0]     inc,
  input  logic [FRAC_BITS-1:0]    lam,
  output logic [INC_OUT_BITS-1:0] head,
  output logic [INC_OUT_BITS-1:0] tail
);

  logic                          neg;
  logic [INC_BITS-1:0]           mag;
  logic                          neg_r;
  logic [INC_BITS-1:0]           mag_r;
  logic [INC_BITS+FRAC_BITS-1:0] prod_r;
  logic [INC_BITS-1:0]           hmag;
  logic [INC_BITS-1:0]           tmag;

  // Magnitude of the two's complement increment
  assign neg = inc[INC_BITS-1];
  assign mag = neg ? (~inc + 1'b1) : inc;

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r  <= neg;
      mag_r  <= mag;
      prod_r <= mag * lam;
    end
  end

  // Truncate toward zero, remainder keeps the same sign
  assign hmag = prod_r[FRAC_BITS +: INC_BITS];
  assign tmag = mag_r - hmag;
  assign head = neg_r ? (~{1'b0, hmag} + 1'b1) : {1'b0, hmag};
  assign tail = neg_r ? (~{1'b0, tmag} + 1'b1) : {1'b0, tmag};

endmodule

@@ rtl/iis_out.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iis_out
// Merges the lane results with the segment summary and sends the head and
// tail beats, or a single rejection beat, on the result channel.
// ----------------------------------------------------------------------------
module iis_out import iis_pkg::*; (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   up_valid,
  output logic                                   up_ready,
  input  iis_seg_t                               seg,
  input  logic [NUM_LANES-1:0][INC_OUT_BITS-1:0] heads,
  input  logic [NUM_LANES-1:0][INC_OUT_BITS-1:0] tails,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [OUT_DATA_BITS-1:0]               out_tdata,
  output logic                                   out_tlast,
  output logic                                   out_tuser
);

  iis_state_t                             state_r;
  iis_state_t                             state_nxt;
  logic                                   ok_r;
  logic [TIME_BITS-1:0]                   ts_r;
  logic [TIME_BITS-1:0]                   tc_r;
  logic [DT_BITS-1:0]                     hdt_r;
  logic [DT_BITS-1:0]                     tdt_r;
  logic [NUM_LANES-1:0][INC_OUT_BITS-1:0] hinc_r;
  logic [NUM_LANES-1:0][INC_OUT_BITS-1:0] tinc_r;
  logic                                   load;

  assign up_ready = (state_r == ST_IDLE) || ((state_r == ST_TAIL) && out_tready);
  assign load     = up_valid && up_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (load) state_nxt = seg.rej ? ST_TAIL : ST_HEAD;
      end
      ST_HEAD: begin
        if (out_tready) state_nxt = ST_TAIL;
      end
      ST_TAIL: begin
        if (load) state_nxt = seg.rej ? ST_TAIL : ST_HEAD;
        else if (out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture both segments; a rejected item carries zeros
  always_ff @(posedge clk) begin
    if (load) begin
      ok_r   <= seg.ok && !seg.rej;
      ts_r   <= seg.ts;
      hdt_r  <= seg.hdt;
      hinc_r <= heads;
      tc_r   <= seg.rej ? '0 : seg.tc;
      tdt_r  <= seg.rej ? '0 : seg.tdt;
      tinc_r <= seg.rej ? '0 : tails;
    end
  end

  // Drive the beat that is due
  always_comb begin
    out_tvalid = (state_r != ST_IDLE);
    out_tlast  = (state_r == ST_TAIL);
    out_tuser  = ok_r;
    out_tdata  = '0;
    if (state_r == ST_TAIL) begin
      out_tdata[OUT_FIELD_BITS-1:0] = {tinc_r, tdt_r, tc_r};
    end else begin
      out_tdata[OUT_FIELD_BITS-1:0] = {hinc_r, hdt_r, ts_r};
    end
  end

endmodule

@@ rtl/imu_increment_splitter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_increment_splitter
// Cuts one IMU sample at a split time into head and tail increments.
// ----------------------------------------------------------------------------
// An accepted beat yields a head beat and a tail beat (tlast), or a single
// rejection beat with ok low. The fraction is found by a pipelined divider of
// one stage per fraction bit, then six parallel multiply lanes scale the
// increments; the input stage, each divider stage, the lane and segment
// registers and the output sequencer register the item in turn. The output
// sequencer sends two beats per split and takes one rejected item per cycle while
// the output is ready; the divider stages buffer items while the output stalls.
module imu_increment_splitter import iis_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [MIN_BITS-1:0]      cfg_wr_data,   // min_interval
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // prev_time, curr_time, split_time, sample_dt, angle_inc_x/y/z, vel_inc_x/y/z
  input  logic [IN_DATA_BITS-1:0]  in_tdata,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // seg_time, seg_dt, out_angle_x/y/z, out_vel_x/y/z, zero pad
  output logic [OUT_DATA_BITS-1:0] out_tdata,
  output logic                     out_tlast,     // is_tail
  output logic                     out_tuser      // ok
);

  localparam int LAST = NUM_STAGES - 1;

  logic [MIN_BITS-1:0]                    min_r;
  logic [NUM_STAGES-1:0]                  vld_r;
  logic [NUM_STAGES-1:0]                  vld_nxt;
  logic [NUM_STAGES:0]                    rdy;
  iis_pipe_t                              pipe_s [FRAC_BITS+1];
  iis_pipe_t                              pipe0_nxt;
  iis_pipe_t                              pipe0_r;
  iis_seg_t                               seg_r;
  iis_seg_t                               seg_nxt;
  logic [NUM_LANES-1:0][INC_OUT_BITS-1:0] heads;
  logic [NUM_LANES-1:0][INC_OUT_BITS-1:0] tails;
  logic                                   out_up_ready;
  logic [TIME_BITS-1:0]                   tp;
  logic [TIME_BITS-1:0]                   tc;
  logic [TIME_BITS-1:0]                   ts;
  logic [TIME_BITS-1:0]                   iv;
  logic [TIME_BITS-1:0]                   hd_last;
  logic [TIME_BITS-1:0]                   sdt_ext;
  logic                                   tneg;
  logic [TIME_BITS-1:0]                   tmag;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= '0;
    end else if (cfg_wr_en) begin
      min_r <= cfg_wr_data;
    end
  end

  // Stage handshake: a stage loads when it is empty or its content moves on
  assign rdy[NUM_STAGES] = out_up_ready;
  genvar k;
  generate
    for (k = 0; k < NUM_STAGES; k++) begin : g_rdy
      assign rdy[k] = !vld_r[k] || rdy[k+1];
      if (k == 0) begin : g_first
        assign vld_nxt[k] = rdy[k] ? in_tvalid : vld_r[k];
      end else begin : g_rest
        assign vld_nxt[k] = rdy[k] ? vld_r[k-1] : vld_r[k];
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready = rdy[0];

  // Input stage: interval, offset and acceptance of the split
  assign tp = in_tdata[0 +: TIME_BITS];
  assign tc = in_tdata[TIME_BITS +: TIME_BITS];
  assign ts = in_tdata[2*TIME_BITS +: TIME_BITS];
  assign iv = tc - tp;

  always_comb begin
    pipe0_nxt      = '0;
    pipe0_nxt.flag = (tc > tp) && (iv > {{(TIME_BITS-MIN_BITS){1'b0}}, min_r})
                     && (ts > tp) && (ts < tc);
    pipe0_nxt.tc   = tc;
    pipe0_nxt.ts   = ts;
    pipe0_nxt.hd   = ts - tp;
    pipe0_nxt.iv   = pipe0_nxt.flag ? iv : {{(TIME_BITS-1){1'b0}}, 1'b1};
    pipe0_nxt.rem  = pipe0_nxt.flag ? pipe0_nxt.hd : '0;
    pipe0_nxt.sdt  = in_tdata[3*TIME_BITS +: SDT_BITS];
    pipe0_nxt.inc  = in_tdata[3*TIME_BITS+SDT_BITS +: NUM_LANES*INC_BITS];
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      pipe0_r <= pipe0_nxt;
    end
  end

  assign pipe_s[0] = pipe0_r;

  // Divider stages, one quotient bit each
  genvar g;
  generate
    for (g = 0; g < FRAC_BITS; g++) begin : g_div
      iis_div_stage u_div (
        .clk   (clk),
        .en    (rdy[g+1]),
        .d_in  (pipe_s[g]),
        .d_out (pipe_s[g+1])
      );
    end
  endgenerate

  // Segment times, dt saturation and the ok test
  assign hd_last = pipe_s[FRAC_BITS].hd;
  assign sdt_ext = {{(TIME_BITS-SDT_BITS){1'b0}}, pipe_s[FRAC_BITS].sdt};
  assign tneg    = hd_last > sdt_ext;
  assign tmag    = tneg ? (hd_last - sdt_ext) : (sdt_ext - hd_last);

  always_comb begin
    seg_nxt     = '0;
    seg_nxt.rej = !pipe_s[FRAC_BITS].flag || (pipe_s[FRAC_BITS].q == '0);
    seg_nxt.ok  = !tneg && (tmag > {{(TIME_BITS-MIN_BITS){1'b0}}, min_r});
    seg_nxt.ts  = pipe_s[FRAC_BITS].ts;
    seg_nxt.tc  = pipe_s[FRAC_BITS].tc;
    if (hd_last[TIME_BITS-1:DT_BITS-1] != '0) begin
      seg_nxt.hdt = {1'b0, {(DT_BITS-1){1'b1}}};
    end else begin
      seg_nxt.hdt = {1'b0, hd_last[DT_BITS-2:0]};
    end
    if (tneg) begin
      if (tmag > {{(TIME_BITS-DT_BITS){1'b0}}, 1'b1, {(DT_BITS-1){1'b0}}}) begin
        seg_nxt.tdt = {1'b1, {(DT_BITS-1){1'b0}}};
      end else begin
        seg_nxt.tdt = ~tmag[DT_BITS-1:0] + 1'b1;
      end
    end else if (tmag[TIME_BITS-1:DT_BITS-1] != '0) begin
      seg_nxt.tdt = {1'b0, {(DT_BITS-1){1'b1}}};
    end else begin
      seg_nxt.tdt = {1'b0, tmag[DT_BITS-2:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[LAST]) begin
      seg_r <= seg_nxt;
    end
  end

  // Multiply lanes
  generate
    for (g = 0; g < NUM_LANES; g++) begin : g_lane
      iis_lane u_lane (
        .clk  (clk),
        .en   (rdy[LAST]),
        .inc  (pipe_s[FRAC_BITS].inc[g]),
        .lam  (pipe_s[FRAC_BITS].q),
        .head (heads[g]),
        .tail (tails[g])
      );
    end
  endgenerate

  // Merge and send
  iis_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (vld_r[LAST]),
    .up_ready   (out_up_ready),
    .seg        (seg_r),
    .heads      (heads),
    .tails      (tails),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // A taken head beat is followed by its tail beat
  a_head_then_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid && out_tlast)
    else $error("head beat not followed by tail beat");

  // Head and tail of one split share the ok flag
  a_same_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tuser == $past(out_tuser))
    else $error("ok differs between head and tail");

  // Tail time lies after the split time
  a_tail_later: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tdata[TIME_BITS-1:0] > $past(out_tdata[TIME_BITS-1:0]))
    else $error("tail time not after split time");

endmodule

@@ sim/iis_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iis_checker
// Watches the input and result streams of the IMU increment splitter, predicts
// the head and tail segments, or the single rejection beat, of every accepted beat
// and compares each result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module iis_checker import iis_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [MIN_BITS-1:0]      cfg_wr_data,
  input  logic                     in_tvalid,
  input  logic                     in_tready,
  input  logic [IN_DATA_BITS-1:0]  in_tdata,
  input  logic                     out_tvalid,
  input  logic                     out_tready,
  input  logic [OUT_DATA_BITS-1:0] out_tdata,
  input  logic                     out_tlast,
  input  logic                     out_tuser,
  output int                       fail_count,
  output int                       pending,
  output int                       split_count,
  output int                       reject_count
);

  typedef struct packed {
    logic                                   ok;
    logic                                   tail;
    logic [TIME_BITS-1:0]                   seg_time;
    logic [DT_BITS-1:0]                     seg_dt;
    logic [NUM_LANES-1:0][INC_OUT_BITS-1:0] incs;
  } segment_t;

  segment_t             seg_q[$];
  logic [MIN_BITS-1:0]  min_iv;

  assign pending = seg_q.size();

  // Saturate a signed magnitude into the dt field
  function automatic logic [DT_BITS-1:0] clamp_dt(bit neg, logic [63:0] mag);
    logic [63:0] lim;
    lim = 64'd1 << (DT_BITS - 1);
    if (neg) begin
      if (mag > lim) mag = lim;
      return DT_BITS'(-mag);
    end
    if (mag > lim - 1) mag = lim - 1;
    return DT_BITS'(mag);
  endfunction

  // Work out the head and tail segments of one input beat
  task automatic split_sample(logic [IN_DATA_BITS-1:0] d);
    logic [TIME_BITS-1:0] tp, tc, ts;
    logic [SDT_BITS-1:0]  sdt;
    logic [63:0]          hd, tmag;
    logic [FRAC_BITS-1:0] lam;
    logic [INC_BITS-1:0]  v, mag;
    logic [95:0]          prod;
    logic [INC_BITS-1:0]  hmag;
    bit                   tneg, ok, neg;
    segment_t             h, t;
    tp  = d[0 +: TIME_BITS];
    tc  = d[TIME_BITS +: TIME_BITS];
    ts  = d[2*TIME_BITS +: TIME_BITS];
    sdt = d[3*TIME_BITS +: SDT_BITS];
    lam = '0;
    if (tc > tp && (tc - tp) > min_iv && ts > tp && ts < tc)
      lam = FRAC_BITS'(({64'd0, 64'(ts - tp)} << FRAC_BITS) / (tc - tp));
    if (lam == 0) begin
      t = '0;
      t.tail = 1'b1;
      seg_q = {seg_q, t};
      reject_count++;
      return;
    end
    hd   = ts - tp;
    tneg = hd > sdt;
    tmag = tneg ? hd - sdt : sdt - hd;
    ok   = !tneg && tmag > min_iv;
    h = '0;
    t = '0;
    h.ok = ok;
    t.ok = ok;
    t.tail = 1'b1;
    h.seg_time = ts;
    t.seg_time = tc;
    h.seg_dt = clamp_dt(1'b0, hd);
    t.seg_dt = clamp_dt(tneg, tmag);
    for (int j = 0; j < NUM_LANES; j++) begin
      v    = d[3*TIME_BITS + SDT_BITS + j*INC_BITS +: INC_BITS];
      neg  = v[INC_BITS-1];
      mag  = neg ? -v : v;
      prod = mag * lam;
      hmag = INC_BITS'(prod >> FRAC_BITS);
      h.incs[j] = neg ? -INC_OUT_BITS'(hmag) : INC_OUT_BITS'(hmag);
      t.incs[j] = neg ? -INC_OUT_BITS'(mag - hmag) : INC_OUT_BITS'(mag - hmag);
    end
    seg_q = {seg_q, h, t};
    split_count++;
  endtask

  task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial begin
    fail_count   = 0;
    split_count  = 0;
    reject_count = 0;
  end

  // Track the register, predict on input beats, check on result beats
  always @(posedge clk) begin
    segment_t e;
    if (!rst_n) begin
      min_iv <= '0;
    end else begin
      if (cfg_wr_en) min_iv <= cfg_wr_data;
      if (in_tvalid && in_tready) split_sample(in_tdata);
      if (out_tvalid && out_tready) begin
        if (seg_q.size() == 0) begin
          $error("result beat with no prediction pending");
          fail_count++;
        end else begin
          e = seg_q.pop_front();
          compare_field("ok", e.ok, out_tuser);
          compare_field("is_tail", e.tail, out_tlast);
          compare_field("seg_time", e.seg_time, out_tdata[0 +: TIME_BITS]);
          compare_field("seg_dt", e.seg_dt, out_tdata[TIME_BITS +: DT_BITS]);
          for (int j = 0; j < NUM_LANES; j++)
            compare_field($sformatf("inc_lane%0d", j), e.incs[j],
                          out_tdata[TIME_BITS + DT_BITS + j*INC_OUT_BITS +: INC_OUT_BITS]);
        end
      end
    end
  end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the IMU increment splitter: directed corner samples, then
// random splits and rejections under several interval minimums, with random
// gaps on both streams. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import iis_pkg::*;

  localparam int NUM_RANDOM = 1830;
  localparam int DRAIN_CYCLES = 3 * NUM_STAGES;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_wr_en = 1'b0;
  logic [MIN_BITS-1:0]      cfg_wr_data = '0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata = '0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic                     out_tlast;
  logic                     out_tuser;
  int                       fail_count, pending, split_count, reject_count;
  bit                       quiet = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  imu_increment_splitter u_dut (.*);

  iis_checker u_chk (.*);

  // Result side back-pressure in random bursts
  initial begin
    int n;
    while (1) begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 8);
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  function automatic logic [31:0] rand_inc();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'(int'($urandom_range(0, 200)) - 100);
      default: return $urandom();
    endcase
  endfunction

  // Send one sample and wait for the block to take it; valid stays high
  // into the next sample unless a gap is taken
  task automatic send_sample(logic [47:0] tp, logic [47:0] tc, logic [47:0] ts,
                             logic [31:0] sdt, bit rand_incs);
    logic [IN_DATA_BITS-1:0] d;
    int n;
    d = {tp, tc, ts, sdt} == 0 ? '0 : '0;
    d[0 +: 48]  = tp;
    d[48 +: 48] = tc;
    d[96 +: 48] = ts;
    d[144 +: 32] = sdt;
    for (int j = 0; j < NUM_LANES; j++)
      d[176 + 32*j +: 32] = rand_incs ? rand_inc() : 32'h8000_0000 >> (j * 5);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 8);
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_min(logic [MIN_BITS-1:0] v);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Random sample: mostly well-formed splits, some rejects and extremes
  task automatic random_sample();
    logic [47:0] tp, tc, ts, iv;
    logic [31:0] sdt;
    tp = {$urandom(), $urandom()};
    case ($urandom_range(0, 9))
      0: iv = 48'($urandom_range(0, 1100));
      1: iv = {$urandom(), $urandom()};
      default: iv = 48'($urandom_range(1, 100000));
    endcase
    tc = tp + iv;
    if ($urandom_range(0, 15) == 0) begin
      ts = {$urandom(), $urandom()};
      tc = {$urandom(), $urandom()};
    end else if (iv > 1 && $urandom_range(0, 7) != 0)
      ts = tp + 48'({$urandom(), $urandom()} % (iv - 1)) + 1;
    else
      ts = $urandom_range(0, 1) ? tp : tc;
    case ($urandom_range(0, 5))
      0: sdt = $urandom();
      1: sdt = 32'(ts - tp) + $urandom_range(0, 1100) - 500;
      default: sdt = 32'(iv) + $urandom_range(0, 200) - 100;
    endcase
    send_sample(tp, tc, ts, sdt, 1'b1);
  endtask

  initial begin
    logic [47:0] tmax;
    tmax = '1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset minimum, extremes, each rejection reason
    send_sample(0, 100, 50, 100, 1'b0);
    send_sample(0, tmax, tmax - 1, 32'hffff_ffff, 1'b0);
    send_sample(0, tmax, 1, 0, 1'b1);
    send_sample(tmax - 2, tmax, tmax - 1, 1, 1'b1);
    send_sample(100, 100, 100, 5, 1'b1);
    send_sample(200, 100, 150, 5, 1'b1);
    send_sample(100, 200, 100, 5, 1'b1);
    send_sample(100, 200, 200, 5, 1'b1);
    send_sample(0, tmax, 1, 5, 1'b0);
    send_sample(0, 48'h1_0000_0001, 48'h1_0000_0000, 0, 1'b1);
    send_sample(0, 2, 1, 1, 1'b0);
    write_min(10'd1023);
    send_sample(0, 1023, 500, 2000, 1'b1);
    send_sample(0, 1024, 1, 1025, 1'b1);
    send_sample(0, 1024, 1, 1024, 1'b1);
    send_sample(0, 5000, 4000, 100, 1'b1);
    send_sample(0, 5000, 4000, 32'hffff_ffff, 1'b0);
    write_min(10'd0);
    send_sample(0, 10, 9, 9, 1'b1);
    send_sample(0, 10, 9, 10, 1'b1);

    // Random phases across minimum settings
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i % 300 == 150)
        write_min(i % 600 == 150 ? MIN_BITS'($urandom_range(0, 1023)) : '1);
      if (i == 900) wait_idle();
      if (i == NUM_RANDOM - 200) quiet = 1'b1;
      random_sample();
    end

    wait_idle();
    $display("covered %0d splits and %0d rejections under several interval minimums",
             split_count, reject_count);
    if (fail_count == 0)
      $display("imu_increment_splitter: match");
    else
      $display("imu_increment_splitter: mismatch");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("imu_increment_splitter: mismatch");
    $finish;
  end

endmodule

@@ imu_increment_splitter.f @@
rtl/iis_pkg.sv
rtl/iis_div_stage.sv
rtl/iis_lane.sv
rtl/iis_out.sv
rtl/imu_increment_splitter.sv
sim/iis_checker.sv
sim/tb_top.sv
